[hdl/bve_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bve_pkg
// shared types and field widths of the bounded vector engine
// ----------------------------------------------------------------------------
package bve_pkg;

    localparam int MODE_W  = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = 5;
    localparam int ERR_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        OP_APPEND = 3'd0,
        OP_REMOVE = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2,
        ERR_RANGE = 2'd3
    } err_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic en;
        op_t  op;
    } cell_cmd_t;

endpackage

`default_nettype wire

[hdl/bve_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bve_req_if
// request channel: one operation item with valid/ready handshake
// ----------------------------------------------------------------------------
interface bve_req_if;
    logic                        valid;
    logic                        ready;
    logic [bve_pkg::MODE_W-1:0]  mode;
    logic [bve_pkg::POS_W-1:0]   position;
    logic [bve_pkg::VALUE_W-1:0] value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

`default_nettype wire

[hdl/bve_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bve_rsp_if
// response channel: one result item with valid/ready handshake
// ----------------------------------------------------------------------------
interface bve_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bve_pkg::VALUE_W-1:0] read_value;
    logic [bve_pkg::IDX_W-1:0]   result_index;
    logic [bve_pkg::IDX_W-1:0]   element_count;
    logic                        is_empty;
    logic [bve_pkg::ERR_W-1:0]   error_code;

    modport source (output valid, output read_value, output result_index,
                    output element_count, output is_empty, output error_code,
                    input ready);
    modport sink   (input valid, input read_value, input result_index,
                    input element_count, input is_empty, input error_code,
                    output ready);
endinterface

`default_nettype wire

[hdl/bounded_vector_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_vector_engine
// fixed-capacity ordered array built as a chain of shifting cells
// ----------------------------------------------------------------------------
// latency: the result item is registered at the edge that accepts the request
//   and is offered on rsp in the next cycle
// throughput: one item per cycle while rsp.ready is high; every cell shifts or loads in a single step
// reset: rst_n clears the element count and the result valid flag; element
//   cells are not reset, only entries below the count are ever visible
// ----------------------------------------------------------------------------
module bounded_vector_engine #(
    parameter int DEPTH      = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bve_req_if.sink    req,
    bve_rsp_if.source  rsp
);

    // count width holds DEPTH itself; compare width also covers the position field
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > bve_pkg::POS_W) ? CW : bve_pkg::POS_W;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    // result register
    logic                        rsp_valid_reg;
    logic [bve_pkg::VALUE_W-1:0] read_value_reg;
    logic [bve_pkg::IDX_W-1:0]   result_index_reg;
    logic [bve_pkg::IDX_W-1:0]   element_count_reg;
    logic                        is_empty_reg;
    bve_pkg::err_t               error_code_reg;

    logic                        accept;
    bve_pkg::op_t                op;
    bve_pkg::err_t               err;
    logic [bve_pkg::IDX_W-1:0]   idx;
    logic                        mutate;
    logic                        rd_sel;
    logic [PW-1:0]               pos_ext;
    logic [PW-1:0]               cnt_ext;
    logic                        full;
    logic                        empty;
    bve_pkg::cell_cmd_t          cell_cmd;
    logic [ELEM_WIDTH-1:0]       val_cut;
    logic [ELEM_WIDTH-1:0]       rd_or;

    logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
    logic [ELEM_WIDTH-1:0] hit_data  [DEPTH];

    // a new item enters when no result is held or while the held result is being taken
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign op      = bve_pkg::op_t'(req.mode);
    assign pos_ext = PW'(req.position);
    assign cnt_ext = PW'(cnt_reg);
    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign val_cut = ELEM_WIDTH'(req.value);

    // operation decode and bounds checks
    always_comb
    begin
        err      = bve_pkg::ERR_OK;
        idx      = '0;
        cnt_next = cnt_reg;
        mutate   = 1'b0;
        rd_sel   = 1'b0;
        case (op)
            bve_pkg::OP_APPEND:
            begin
                if (full)
                begin
                    err = bve_pkg::ERR_FULL;
                end
                else
                begin
                    idx      = bve_pkg::IDX_W'(cnt_reg);
                    cnt_next = cnt_reg + CW'(1);
                    mutate   = 1'b1;
                end
            end
            bve_pkg::OP_REMOVE:
            begin
                if (empty)
                begin
                    err = bve_pkg::ERR_EMPTY;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            bve_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    err = bve_pkg::ERR_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    err = bve_pkg::ERR_RANGE;
                end
                else
                begin
                    idx      = req.position;
                    cnt_next = cnt_reg + CW'(1);
                    mutate   = 1'b1;
                end
            end
            bve_pkg::OP_ERASE:
            begin
                if (empty)
                begin
                    err = bve_pkg::ERR_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    err = bve_pkg::ERR_RANGE;
                end
                else
                begin
                    idx      = req.position;
                    cnt_next = cnt_reg - CW'(1);
                    mutate   = 1'b1;
                end
            end
            bve_pkg::OP_CLEAR:
            begin
                cnt_next = '0;
            end
            bve_pkg::OP_READ:
            begin
                if (empty)
                begin
                    err = bve_pkg::ERR_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    err = bve_pkg::ERR_RANGE;
                end
                else
                begin
                    idx    = req.position;
                    rd_sel = 1'b1;
                end
            end
            default:
            begin
                // unused modes leave everything as it is
                err = bve_pkg::ERR_OK;
            end
        endcase
    end

    // cells act only on an accepted item that passed its checks
    assign cell_cmd.en = accept && mutate;
    assign cell_cmd.op = op;

    // chain of cells; neighbors at the ends are never selected
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ELEM_WIDTH-1:0] left_d;
        logic [ELEM_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        bve_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .CW         (CW),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cell_cmd),
            .pos        (CW'(req.position)),
            .cnt        (cnt_reg),
            .val        (val_cut),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .hit_data   (hit_data[i])
        );
    end

    // read port: at most one cell matches the position, so its data is or-ed out
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_or = rd_or | hit_data[i];
        end
    end

    // count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg       <= cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg    <= rd_sel ? bve_pkg::VALUE_W'(rd_or) : '0;
            result_index_reg  <= idx;
            element_count_reg <= bve_pkg::IDX_W'(cnt_next);
            is_empty_reg      <= (cnt_next == '0);
            error_code_reg    <= err;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_value    = read_value_reg;
    assign rsp.result_index  = result_index_reg;
    assign rsp.element_count = element_count_reg;
    assign rsp.is_empty      = is_empty_reg;
    assign rsp.error_code    = error_code_reg;

endmodule

`default_nettype wire

[hdl/bve_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bve_cell
// one element slot of the chain: loads, shifts up or shifts down
// ----------------------------------------------------------------------------
module bve_cell #(
    parameter int ELEM_WIDTH = 32,
    parameter int CW         = 5,
    parameter int IDX        = 0
) (
    input  wire logic                     clk,
    input  wire bve_pkg::cell_cmd_t       cmd,
    input  wire logic [CW-1:0]            pos,
    input  wire logic [CW-1:0]            cnt,
    input  wire logic [ELEM_WIDTH-1:0]    val,
    input  wire logic [ELEM_WIDTH-1:0]    left_data,
    input  wire logic [ELEM_WIDTH-1:0]    right_data,
    output logic      [ELEM_WIDTH-1:0]    data,
    output logic      [ELEM_WIDTH-1:0]    hit_data
);

    localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
    localparam logic [CW:0]   MY_IDX_1 = (CW + 1)'(IDX + 1);

    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.en)
        begin
            case (cmd.op)
                bve_pkg::OP_APPEND:
                begin
                    if (MY_IDX == cnt)
                    begin
                        data_next = val;
                    end
                end
                bve_pkg::OP_INSERT:
                begin
                    if (MY_IDX == pos)
                    begin
                        data_next = val;
                    end
                    else if (MY_IDX > pos && MY_IDX <= cnt)
                    begin
                        data_next = left_data;
                    end
                end
                bve_pkg::OP_ERASE:
                begin
                    if (MY_IDX >= pos && MY_IDX_1 < {1'b0, cnt})
                    begin
                        data_next = right_data;
                    end
                end
                default:
                begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    // element storage is not reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign hit_data = (MY_IDX == pos) ? data_reg : '0;

endmodule

`default_nettype wire
